FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/swq_pkg.sv
// ----------------------------------------------------------------------------
// swq_pkg
// Shared types and codes of the semaphore wait queue.
// ----------------------------------------------------------------------------
package swq_pkg;

   localparam logic [1:0] OP_ACQUIRE  = 2'd0;
   localparam logic [1:0] OP_RELEASE  = 2'd1;
   localparam logic [1:0] OP_WITHDRAW = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } swq_state_type;

   typedef struct packed {
      logic granted;
      logic queued;
      logic overflow;
      logic woken_valid;
      logic found;
   } swq_flags_type;

endpackage

FILE: src/swq_ram.sv
// ----------------------------------------------------------------------------
// swq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/semaphore_with_wait_queue_unit.sv
// ----------------------------------------------------------------------------
// semaphore_with_wait_queue_unit
// Binary semaphore with an in-order wait queue of task ids held in a RAM.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                  Word
//  req_     in   req_valid / req_ready      opcode, task id
//  rsp_     out  rsp_valid / rsp_ready      grant, queue, overflow, wake, withdraw
//  csr_     in   csr_write_enable (no wait) starts_available, loaded into flag
//
//  Acquire, release on an empty queue and the unused opcode answer without a scan.
//  Withdraw and release on a non-empty queue scan the whole queue first: the scan
//  reads one queue entry per cycle through the single RAM read port.
//  Reset (synchronous): flag set, queue empty; queue RAM is not cleared.
//  A result waits in the output register; a new word is taken meanwhile, and
//  its result is held back until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module semaphore_with_wait_queue_unit #(
   parameter int QUEUE_DEPTH  = 8,
   parameter int TASK_ID_BITS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   // request
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_opcode,
   input  logic [TASK_ID_BITS-1:0] req_task_id,
   // response
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_granted,
   output logic                    rsp_queued,
   output logic                    rsp_overflow,
   output logic                    rsp_woken_valid,
   output logic [TASK_ID_BITS-1:0] rsp_woken_task,
   output logic                    rsp_withdrawn_found,
   output logic                    rsp_has_waiters,
   // configuration
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data
);

   import swq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // control state
   swq_state_type             state_ff, state_in;
   logic                      flag_ff, flag_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // working registers of the current word
   logic [1:0]                op_ff, op_in;
   logic [TASK_ID_BITS-1:0]   id_ff, id_in;
   logic [AW-1:0]             scan_ff, scan_in;   // index of entry arriving from RAM
   logic [CW-1:0]             wr_ff, wr_in;       // compaction write pointer
   logic                      first_ff, first_in;
   swq_flags_type             res_ff, res_in;
   logic [TASK_ID_BITS-1:0]   woken_ff, woken_in;

   // output register
   swq_flags_type             rsp_flags_ff, rsp_flags_in;
   logic [TASK_ID_BITS-1:0]   rsp_woken_ff, rsp_woken_in;
   logic                      rsp_waiters_ff, rsp_waiters_in;

   // queue RAM
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [TASK_ID_BITS-1:0]   mem_wdata;
   logic [AW-1:0]             mem_raddr;
   logic [TASK_ID_BITS-1:0]   mem_rdata;

   // scan datapath: the one task id comparator
   logic [TASK_ID_BITS-1:0]   target;
   logic                      hit;
   logic                      last;
   logic [CW-1:0]             wr_next;

   swq_ram #(
      .WIDTH (TASK_ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      // release takes the head entry as its target on the first scan step and
      // keeps it from the woken register after that
      target  = (op_ff == OP_RELEASE) ? (first_ff ? mem_rdata : woken_ff) : id_ff;
      hit     = (mem_rdata == target);
      last    = (CW'(scan_ff) == (count_ff - 1'b1));
      wr_next = hit ? wr_ff : (wr_ff + 1'b1);
   end

   always_comb begin
      state_in       = state_ff;
      flag_in        = flag_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      scan_in        = scan_ff;
      wr_in          = wr_ff;
      first_in       = first_ff;
      res_in         = res_ff;
      woken_in       = woken_ff;
      rsp_flags_in   = rsp_flags_ff;
      rsp_woken_in   = rsp_woken_ff;
      rsp_waiters_in = rsp_waiters_ff;
      req_ready      = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = AW'(count_ff);
      mem_wdata      = req_task_id;
      mem_raddr      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_raddr = '0;            // head entry, in case a scan follows
            if (req_valid) begin
               op_in    = req_opcode;
               id_in    = req_task_id;
               res_in   = '0;
               woken_in = '0;
               scan_in  = '0;
               wr_in    = '0;
               first_in = 1'b1;
               state_in = ST_RESP;
               case (req_opcode)
                  OP_ACQUIRE: begin
                     if (flag_ff) begin
                        flag_in        = 1'b0;
                        res_in.granted = 1'b1;
                     end else if (count_ff >= DEPTH_C) begin
                        res_in.overflow = 1'b1;
                     end else begin
                        mem_we        = 1'b1;
                        count_in      = count_ff + 1'b1;
                        res_in.queued = 1'b1;
                     end
                  end
                  OP_RELEASE: begin
                     if (count_ff == '0) begin
                        flag_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_WITHDRAW: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            mem_raddr = AW'(scan_ff + 1'b1);
            mem_waddr = AW'(wr_ff);
            mem_wdata = mem_rdata;
            first_in  = 1'b0;
            if (first_ff && (op_ff == OP_RELEASE)) begin
               woken_in           = mem_rdata;
               res_in.woken_valid = 1'b1;
            end
            if (hit) begin
               res_in.found = (op_ff == OP_WITHDRAW);
            end else begin
               mem_we = 1'b1;
            end
            wr_in = wr_next;
            if (last) begin
               count_in = wr_next;
               state_in = ST_RESP;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_flags_in   = res_ff;
               rsp_woken_in   = woken_ff;
               rsp_waiters_in = (count_ff != '0);
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write loads the flag directly; the user must write it only while idle, the block does not enforce this
      if (csr_write_enable) begin
         flag_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      id_ff          <= id_in;
      scan_ff        <= scan_in;
      wr_ff          <= wr_in;
      first_ff       <= first_in;
      res_ff         <= res_in;
      woken_ff       <= woken_in;
      rsp_flags_ff   <= rsp_flags_in;
      rsp_woken_ff   <= rsp_woken_in;
      rsp_waiters_ff <= rsp_waiters_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted         = rsp_flags_ff.granted;
   assign rsp_queued          = rsp_flags_ff.queued;
   assign rsp_overflow        = rsp_flags_ff.overflow;
   assign rsp_woken_valid     = rsp_flags_ff.woken_valid;
   assign rsp_woken_task      = rsp_woken_ff;
   assign rsp_withdrawn_found = rsp_flags_ff.found;
   assign rsp_has_waiters     = rsp_waiters_ff;

   // checks
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C, "queue count above depth")
   `ASSERT_IMPL(a_wr_behind_rd, clock, reset, state_ff == ST_SCAN, wr_ff <= CW'(scan_ff), "compaction write overtook read")
   `ASSERT_IMPL(a_acq_onehot, clock, reset, rsp_valid, $onehot0({rsp_granted, rsp_queued, rsp_overflow}), "acquire outcomes overlap")
   `ASSERT_NEXT(a_scan_shrinks, clock, reset, (state_ff == ST_SCAN) && last && (op_ff == OP_RELEASE) && first_ff, count_ff < $past(count_ff), "release did not shrink queue")

endmodule

FILE: verif/swq_checker.sv
// ----------------------------------------------------------------------------
// swq_checker
// Watches both channels of the semaphore unit, models the flag and wait queue
// and checks every response word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module swq_checker #(
   parameter int QUEUE_DEPTH  = 8,
   parameter int TASK_ID_BITS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [1:0]              req_opcode,
   input  logic [TASK_ID_BITS-1:0] req_task_id,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_granted,
   input  logic                    rsp_queued,
   input  logic                    rsp_overflow,
   input  logic                    rsp_woken_valid,
   input  logic [TASK_ID_BITS-1:0] rsp_woken_task,
   input  logic                    rsp_withdrawn_found,
   input  logic                    rsp_has_waiters,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   output int                      pending,
   output int                      fail_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import swq_pkg::*;

   typedef struct packed {
      logic                    granted;
      logic                    queued;
      logic                    overflow;
      logic                    woken_valid;
      logic [TASK_ID_BITS-1:0] woken_task;
      logic                    found;
      logic                    has_waiters;
   } outcome_type;

   logic                    flag       = 1'b1;
   logic [TASK_ID_BITS-1:0] waiters[QUEUE_DEPTH];
   int                      n_waiting  = 0;
   outcome_type             outcome_q[$];
   int                      n_fail     = 0;

   assign fail_count = n_fail;

   // drop every queued copy of id, keeping the order of the rest
   function automatic logic drop_task(input logic [TASK_ID_BITS-1:0] id);
      int   wr;
      logic hit;
      wr  = 0;
      hit = 1'b0;
      for (int rd = 0; rd < n_waiting; rd++) begin
         if (waiters[rd] != id) begin
            waiters[wr] = waiters[rd];
            wr++;
         end else begin
            hit = 1'b1;
         end
      end
      n_waiting = wr;
      return hit;
   endfunction

   function automatic outcome_type resolve_request(input logic [1:0]              op,
                                                   input logic [TASK_ID_BITS-1:0] id);
      outcome_type o;
      o = '0;
      case (op)
         OP_ACQUIRE: begin
            if (flag) begin
               flag      = 1'b0;
               o.granted = 1'b1;
            end else if (n_waiting >= QUEUE_DEPTH) begin
               o.overflow = 1'b1;
            end else begin
               waiters[n_waiting] = id;
               n_waiting++;
               o.queued = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (n_waiting == 0) begin
               flag = 1'b1;
            end else begin
               o.woken_task  = waiters[0];
               o.woken_valid = 1'b1;
               void'(drop_task(o.woken_task));
            end
         end
         OP_WITHDRAW: o.found = drop_task(id);
         default: ;  // spare code: state untouched
      endcase
      o.has_waiters = (n_waiting != 0);
      return o;
   endfunction

   task automatic note_failure(input string what, input outcome_type want,
                               input outcome_type seen);
      n_fail++;
      if (n_fail <= 10)
         $display("%t %s: exp g%0b q%0b o%0b w%0b t%0d f%0b h%0b  act g%0b q%0b o%0b w%0b t%0d f%0b h%0b",
                  $realtime, what,
                  want.granted, want.queued, want.overflow, want.woken_valid,
                  want.woken_task, want.found, want.has_waiters,
                  seen.granted, seen.queued, seen.overflow, seen.woken_valid,
                  seen.woken_task, seen.found, seen.has_waiters);
   endtask

   always @(posedge clock) begin : monitor
      outcome_type seen;
      outcome_type want;
      if (reset) begin
         flag       = 1'b1;
         n_waiting  = 0;
         outcome_q.delete();
         pending <= 0;
      end else begin
         if (csr_write_enable) begin
            flag       = csr_write_data;
         end
         // compare before the push: a word leaving now is never the one entering
         if (rsp_valid && rsp_ready) begin
            seen.granted     = rsp_granted;
            seen.queued      = rsp_queued;
            seen.overflow    = rsp_overflow;
            seen.woken_valid = rsp_woken_valid;
            seen.woken_task  = rsp_woken_task;
            seen.found       = rsp_withdrawn_found;
            seen.has_waiters = rsp_has_waiters;
            if (outcome_q.size() == 0) begin
               note_failure("unexpected response", '0, seen);
            end else begin
               want = outcome_q.pop_front();
               if (seen !== want) note_failure("response mismatch", want, seen);
            end
         end
         if (req_valid && req_ready)
            outcome_q.push_back(resolve_request(req_opcode, req_task_id));
         pending <= outcome_q.size();
      end
   end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the semaphore wait queue unit: a directed run over the corner
// cases, then random phases under both flag settings, with random stalls on
// both channels. Checking is done by swq_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import swq_pkg::*;

   localparam int QUEUE_DEPTH  = 8;
   localparam int TASK_ID_BITS = 4;
   // cycles without any handshake before the run is declared hung; well above
   // the long receiver hold-off and the longest release scan
   localparam int IDLE_LIMIT   = 5000;
   // the package only names the three real operations
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_opcode = OP_ACQUIRE;
   logic [TASK_ID_BITS-1:0] req_task_id = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_granted;
   logic                    rsp_queued;
   logic                    rsp_overflow;
   logic                    rsp_woken_valid;
   logic [TASK_ID_BITS-1:0] rsp_woken_task;
   logic                    rsp_withdrawn_found;
   logic                    rsp_has_waiters;
   logic                    csr_write_enable = 1'b0;
   logic                    csr_write_data = 1'b0;

   int pending;
   int fail_count;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   semaphore_with_wait_queue_unit #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_task_id         (req_task_id),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted         (rsp_granted),
      .rsp_queued          (rsp_queued),
      .rsp_overflow        (rsp_overflow),
      .rsp_woken_valid     (rsp_woken_valid),
      .rsp_woken_task      (rsp_woken_task),
      .rsp_withdrawn_found (rsp_withdrawn_found),
      .rsp_has_waiters     (rsp_has_waiters),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   swq_checker #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_task_id         (req_task_id),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted         (rsp_granted),
      .rsp_queued          (rsp_queued),
      .rsp_overflow        (rsp_overflow),
      .rsp_woken_valid     (rsp_woken_valid),
      .rsp_woken_task      (rsp_woken_task),
      .rsp_withdrawn_found (rsp_withdrawn_found),
      .rsp_has_waiters     (rsp_has_waiters),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .pending             (pending),
      .fail_count          (fail_count)
   );

   // Idle length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Offer one request word after an optional gap and hold it until taken.
   // With no gap, valid simply stays high into the next word.
   task automatic offer(input logic [1:0] op, input logic [TASK_ID_BITS-1:0] id,
                        input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_task_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Let every outstanding word come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write only with the unit idle; it reloads the flag at once.
   task automatic set_start_flag(input logic value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Directed words, {opcode, task id}.
   // Semaphore mode (flag set from reset): grant, fill the queue with
   // duplicates and the id extremes, overflow, spare opcode, withdraw hit and
   // miss, a release that wakes a duplicated head, drain to the flag, then grant.
   // ------------------------------------------------------------------------
   localparam logic [5:0] SEM_SCRIPT [21] = '{
      {OP_ACQUIRE,  4'd0},   // flag set: granted
      {OP_ACQUIRE,  4'd15},  // queued from here on
      {OP_ACQUIRE,  4'd5},
      {OP_ACQUIRE,  4'd5},   // same id twice
      {OP_ACQUIRE,  4'd3},
      {OP_ACQUIRE,  4'd15},  // copy of the head further back
      {OP_ACQUIRE,  4'd10},
      {OP_ACQUIRE,  4'd7},
      {OP_ACQUIRE,  4'd0},   // queue now full
      {OP_ACQUIRE,  4'd9},   // overflow, nothing changes
      {OP_SPARE,    4'd6},   // only has_waiters
      {OP_WITHDRAW, 4'd5},   // both copies go
      {OP_WITHDRAW, 4'd12},  // absent
      {OP_RELEASE,  4'd0},   // wakes 15 and drops its second copy
      {OP_RELEASE,  4'd0},
      {OP_WITHDRAW, 4'd10},
      {OP_RELEASE,  4'd0},
      {OP_RELEASE,  4'd0},   // last waiter leaves
      {OP_RELEASE,  4'd0},   // empty: flag set
      {OP_SPARE,    4'd15},
      {OP_ACQUIRE,  4'd8}    // granted again
   };

   // Signal mode (flag clear): release sets the flag, acquire takes it, the
   // next acquire waits and the following release wakes it.
   localparam logic [5:0] SIG_SCRIPT [4] = '{
      {OP_RELEASE,  4'd0},
      {OP_ACQUIRE,  4'd2},
      {OP_ACQUIRE,  4'd4},
      {OP_RELEASE,  4'd0}
   };

   // Flag settings of the random phases, both extremes and repeated writes.
   localparam logic PHASE_FLAG [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam int   PHASE_WORDS = 240;

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int               r;
      int               bias;
      bit               quiet;
      logic [1:0]       op;
      logic [TASK_ID_BITS-1:0] id;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (SEM_SCRIPT[i]) offer(SEM_SCRIPT[i][5:4], SEM_SCRIPT[i][3:0], pick_gap());
      set_start_flag(1'b0);
      foreach (SIG_SCRIPT[i]) offer(SIG_SCRIPT[i][5:4], SIG_SCRIPT[i][3:0], pick_gap());

      bias  = 0;
      quiet = 1'b0;
      foreach (PHASE_FLAG[p]) begin
         set_start_flag(PHASE_FLAG[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // bursts lean towards filling, draining, mixing or withdrawing, so
            // the queue swings between empty and full; some bursts run flat out
            if (n % 32 == 0) begin
               bias  = $urandom_range(0, 3);
               quiet = ($urandom_range(0, 4) == 0);
            end
            r = $urandom_range(0, 99);
            case (bias)
               0:       op = (r < 70) ? OP_ACQUIRE : (r < 80) ? OP_RELEASE :
                             (r < 95) ? OP_WITHDRAW : OP_SPARE;
               1:       op = (r < 25) ? OP_ACQUIRE : (r < 75) ? OP_RELEASE :
                             (r < 95) ? OP_WITHDRAW : OP_SPARE;
               2:       op = (r < 40) ? OP_ACQUIRE : (r < 70) ? OP_RELEASE :
                             (r < 93) ? OP_WITHDRAW : OP_SPARE;
               default: op = (r < 35) ? OP_ACQUIRE : (r < 55) ? OP_RELEASE :
                             (r < 95) ? OP_WITHDRAW : OP_SPARE;
            endcase
            // a small pool of ids makes duplicates and withdraw hits common
            if ($urandom_range(0, 3) != 0) id = TASK_ID_BITS'($urandom_range(0, 3));
            else                           id = TASK_ID_BITS'($urandom_range(0, 15));
            offer(op, id, quiet ? 0 : pick_gap());
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: runs of ready broken by stalls, plus one long hold-off
   // once enough words have come back, while requests keep arriving, so the
   // unit backs up and drops req_ready.
   // ------------------------------------------------------------------------
   initial begin : response_side
      int  run_left;
      int  stall_left;
      int  hold_left;
      int  taken;
      bit  held;
      int  r;

      run_left   = 0;
      stall_left = 0;
      hold_left  = 0;
      taken      = 0;
      held       = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_valid && rsp_ready) taken++;
         if (!held && taken >= 400) begin
            held      = 1'b1;
            hold_left = 300;
         end
         if (run_left == 0 && stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 70)      run_left = $urandom_range(1, 8);
            else if (r < 90) run_left = $urandom_range(9, 40);
            else             run_left = $urandom_range(50, 200);
            stall_left = pick_gap();
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_ready <= 1'b1;
         end else begin
            stall_left--;
            rsp_ready <= 1'b0;
         end
         @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any handshake or register write restarts the count.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: sim.f
+incdir+src
src/swq_pkg.sv
src/swq_ram.sv
src/semaphore_with_wait_queue_unit.sv
verif/swq_checker.sv
verif/tb_top.sv
